// File: design/i2cmts_pkg.sv
// shared types and codes for the i2c master transfer sequencer
`default_nettype none
package i2cmts_pkg;

    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;

    typedef enum logic [1:0] {
        REQ_START_WR = 2'd0,
        REQ_START_RD = 2'd1,
        REQ_STATUS   = 2'd2,
        REQ_ERROR    = 2'd3
    } t_req;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TX    = 3'd3,
        PH_RX    = 3'd4,
        PH_ERR   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] target_address;
        logic [BYTE_W-1:0] transfer_length;
        logic              start_sent_flag;
        logic              address_done_flag;
        logic              tx_empty_flag;
        logic              rx_full_flag;
        logic [BYTE_W-1:0] tx_byte;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic               write_data_reg;
        logic [BYTE_W-1:0]  data_reg_value;
        logic               store_received;
        logic [BYTE_W-1:0]  received_byte;
        logic [BYTE_W-1:0]  store_index;
        logic               request_start;
        logic               request_stop;
        logic               set_ack;
        logic               clear_ack;
        logic               read_status2;
        logic [PHASE_W-1:0] phase_now;
    } t_out_item;

    typedef struct packed {
        t_phase            phase;
        logic [ADDR_W-1:0] slave_address;
        logic              read_mode;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] byte_index;
    } t_seq_state;

endpackage
`default_nettype wire

// File: design/i2cmts_in_if.sv
// request channel: valid/ready with one request item
`default_nettype none
interface i2cmts_in_if;
    logic                 valid;
    logic                 ready;
    i2cmts_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/i2cmts_out_if.sv
// result channel: valid/ready with one command item
`default_nettype none
interface i2cmts_out_if;
    logic                  valid;
    logic                  ready;
    i2cmts_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/i2cmts_step.sv
// sequencer next-state and command decode for one request
`default_nettype none
module i2cmts_step (
    input  wire i2cmts_pkg::t_seq_state i_state,
    input  wire i2cmts_pkg::t_in_item   i_item,
    output i2cmts_pkg::t_seq_state      o_state,
    output i2cmts_pkg::t_out_item       o_result
);

    i2cmts_pkg::t_seq_state n_state;
    i2cmts_pkg::t_out_item  n_result;
    logic [i2cmts_pkg::BYTE_W-1:0] idx_inc;
    logic [i2cmts_pkg::BYTE_W-1:0] cnt_dec;
    logic                          tx_more;

    assign idx_inc = i_state.byte_index + i2cmts_pkg::BYTE_W'(1);
    assign cnt_dec = i_state.byte_count - i2cmts_pkg::BYTE_W'(1);
    assign tx_more = (i_state.byte_index < i_state.byte_count);

    // next state
    always_comb begin
        n_state = i_state;
        case (i2cmts_pkg::t_req'(i_item.req_type))
            i2cmts_pkg::REQ_START_WR, i2cmts_pkg::REQ_START_RD: begin
                n_state.slave_address = i_item.target_address;
                n_state.byte_count    = i_item.transfer_length;
                n_state.byte_index    = '0;
                n_state.read_mode     = (i_item.req_type == i2cmts_pkg::REQ_START_RD);
                n_state.phase         = i2cmts_pkg::PH_START;
            end
            i2cmts_pkg::REQ_ERROR: begin
                n_state.phase = i2cmts_pkg::PH_ERR;
            end
            i2cmts_pkg::REQ_STATUS: begin
                case (i_state.phase)
                    i2cmts_pkg::PH_START: begin
                        if (i_item.start_sent_flag) n_state.phase = i2cmts_pkg::PH_ADDR;
                    end
                    i2cmts_pkg::PH_ADDR: begin
                        if (i_item.address_done_flag) begin
                            n_state.phase = i_state.read_mode ? i2cmts_pkg::PH_RX
                                                              : i2cmts_pkg::PH_TX;
                        end
                    end
                    i2cmts_pkg::PH_TX: begin
                        if (i_item.tx_empty_flag) begin
                            if (tx_more) n_state.byte_index = idx_inc;
                            else         n_state.phase      = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_RX: begin
                        if (i_item.rx_full_flag) begin
                            n_state.byte_index = idx_inc;
                            if (idx_inc == i_state.byte_count) n_state.phase = i2cmts_pkg::PH_IDLE;
                        end
                    end
                    i2cmts_pkg::PH_ERR: begin
                        n_state.phase = i2cmts_pkg::PH_IDLE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // commands
    always_comb begin
        n_result = '0;
        case (i2cmts_pkg::t_req'(i_item.req_type))
            i2cmts_pkg::REQ_START_WR, i2cmts_pkg::REQ_START_RD: begin
                n_result.request_start = 1'b1;
                n_result.set_ack       = (i_item.req_type == i2cmts_pkg::REQ_START_RD);
            end
            i2cmts_pkg::REQ_STATUS: begin
                case (i_state.phase)
                    i2cmts_pkg::PH_START: begin
                        if (i_item.start_sent_flag) begin
                            n_result.write_data_reg = 1'b1;
                            n_result.data_reg_value = {i_state.slave_address, i_state.read_mode};
                        end
                    end
                    i2cmts_pkg::PH_ADDR: begin
                        n_result.read_status2 = i_item.address_done_flag;
                    end
                    i2cmts_pkg::PH_TX: begin
                        if (i_item.tx_empty_flag) begin
                            if (tx_more) begin
                                n_result.write_data_reg = 1'b1;
                                n_result.data_reg_value = i_item.tx_byte;
                                n_result.store_index    = i_state.byte_index;
                            end else begin
                                n_result.request_stop = 1'b1;
                            end
                        end
                    end
                    i2cmts_pkg::PH_RX: begin
                        if (i_item.rx_full_flag) begin
                            n_result.store_received = 1'b1;
                            n_result.received_byte  = i_item.rx_byte;
                            n_result.store_index    = i_state.byte_index;
                            // nack ahead of the last byte
                            n_result.clear_ack      = (i_state.byte_count != '0)
                                                      && (idx_inc == cnt_dec);
                            n_result.request_stop   = (idx_inc == i_state.byte_count);
                        end
                    end
                    i2cmts_pkg::PH_ERR: begin
                        n_result.request_stop = 1'b1;
                        n_result.set_ack      = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        n_result.phase_now = n_state.phase;
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule
`default_nettype wire

// File: design/i2c_master_transfer_sequencer_top.sv
// i2c master transfer sequencer: request register, decode, command register
// flow: an accepted request sits in the request register, is decoded, and moves to the
// command register once that register is free; its command is then offered on the output
// throughput: one request per cycle while the output is ready, set by the single decode
// between two registers; if a command waits the input takes one more request, then stalls
// reset (synchronous, active low): phase idle, address/length/index/mode zero
`default_nettype none
module i2c_master_transfer_sequencer_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    i2cmts_in_if.sink       i_in,
    i2cmts_out_if.source    o_out
);

    i2cmts_pkg::t_in_item   r_in;
    logic                   r_in_valid;
    i2cmts_pkg::t_seq_state r_state;
    i2cmts_pkg::t_out_item  r_out;
    logic                   r_out_valid;

    i2cmts_pkg::t_seq_state n_state;
    i2cmts_pkg::t_out_item  n_out;
    logic                   advance;

    // move the held request into the command register when it is free
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    i2cmts_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: i2cmts_pkg::PH_IDLE, default: '0};
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in <= i_in.data;
        if (advance && r_in_valid)    r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire

// File: tb/i2cmts_checker.sv
// checker for the i2c master transfer sequencer: predicts commands and compares them
`timescale 1ns / 100ps
module i2cmts_checker
    import i2cmts_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    i2cmts_in_if        i_req,
    i2cmts_out_if       i_cmd,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    // predicted sequencer state
    t_phase            seq_phase;
    logic [ADDR_W-1:0] seq_addr;
    logic              seq_rd;
    logic [BYTE_W-1:0] seq_len;
    logic [BYTE_W-1:0] seq_idx;

    t_out_item cmd_q[$];
    int        n_fail;
    int        n_report;
    int        n_checked;

    assign o_errors  = n_fail;
    assign o_checked = n_checked;

    function automatic t_out_item next_command(input t_in_item it);
        t_out_item r;
        r = '0;
        case (t_req'(it.req_type))
            REQ_START_WR, REQ_START_RD: begin
                seq_addr  = it.target_address;
                seq_len   = it.transfer_length;
                seq_idx   = '0;
                seq_rd    = (t_req'(it.req_type) == REQ_START_RD);
                seq_phase = PH_START;
                r.set_ack       = seq_rd;
                r.request_start = 1'b1;
            end
            REQ_ERROR: begin
                seq_phase = PH_ERR;
            end
            default: begin
                case (seq_phase)
                    PH_START: begin
                        if (it.start_sent_flag) begin
                            r.write_data_reg = 1'b1;
                            r.data_reg_value = {seq_addr, seq_rd};
                            seq_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (it.address_done_flag) begin
                            r.read_status2 = 1'b1;
                            seq_phase = seq_rd ? PH_RX : PH_TX;
                        end
                    end
                    PH_TX: begin
                        if (it.tx_empty_flag) begin
                            if (seq_idx < seq_len) begin
                                r.write_data_reg = 1'b1;
                                r.data_reg_value = it.tx_byte;
                                r.store_index    = seq_idx;
                                seq_idx = seq_idx + 8'd1;
                            end else begin
                                r.request_stop = 1'b1;
                                seq_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_RX: begin
                        if (it.rx_full_flag) begin
                            r.store_received = 1'b1;
                            r.received_byte  = it.rx_byte;
                            r.store_index    = seq_idx;
                            seq_idx = seq_idx + 8'd1;
                            // ack off ahead of the last byte
                            if (seq_len != 8'd0 && seq_idx == seq_len - 8'd1)
                                r.clear_ack = 1'b1;
                            if (seq_idx == seq_len) begin
                                r.request_stop = 1'b1;
                                seq_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_ERR: begin
                        // recovery ignores the flags
                        r.request_stop = 1'b1;
                        r.set_ack      = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                    default: ;
                endcase
            end
        endcase
        r.phase_now = seq_phase;
        return r;
    endfunction

    task automatic check_field(input string nm, input logic [7:0] want, input logic [7:0] got,
                               inout bit bad);
        if (want !== got) begin
            bad = 1'b1;
            if (n_report < 10)
                $display("%0t: %s mismatch, expected %0h got %0h", $realtime, nm, want, got);
            n_report++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        bit        bad;
        if (!i_rst_n) begin
            seq_phase = PH_IDLE;
            seq_addr  = '0;
            seq_rd    = 1'b0;
            seq_len   = '0;
            seq_idx   = '0;
            cmd_q.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                got = i_cmd.data;
                if (cmd_q.size() == 0) begin
                    n_fail++;
                    if (n_report < 10)
                        $display("%0t: command with nothing expected: %h", $realtime, got);
                    n_report++;
                end else begin
                    want = cmd_q.pop_front();
                    bad  = 1'b0;
                    check_field("write_data_reg", 8'(want.write_data_reg),
                                8'(got.write_data_reg), bad);
                    check_field("data_reg_value", want.data_reg_value, got.data_reg_value, bad);
                    check_field("store_received", 8'(want.store_received),
                                8'(got.store_received), bad);
                    check_field("received_byte", want.received_byte, got.received_byte, bad);
                    check_field("store_index", want.store_index, got.store_index, bad);
                    check_field("request_start", 8'(want.request_start),
                                8'(got.request_start), bad);
                    check_field("request_stop", 8'(want.request_stop),
                                8'(got.request_stop), bad);
                    check_field("set_ack", 8'(want.set_ack), 8'(got.set_ack), bad);
                    check_field("clear_ack", 8'(want.clear_ack), 8'(got.clear_ack), bad);
                    check_field("read_status2", 8'(want.read_status2),
                                8'(got.read_status2), bad);
                    check_field("phase_now", 8'(want.phase_now), 8'(got.phase_now), bad);
                    if (bad)
                        n_fail++;
                    n_checked++;
                end
            end
            if (i_req.valid && i_req.ready)
                cmd_q.push_back(next_command(i_req.data));
        end
        o_pending <= cmd_q.size();
    end

endmodule

// File: tb/tb_top.sv
// testbench top for the i2c master transfer sequencer: stimulus, output stalls, verdict
`timescale 1ns / 100ps
module tb_top;
    import i2cmts_pkg::*;

    localparam logic [3:0] F_SB   = 4'b1000;
    localparam logic [3:0] F_ADF  = 4'b0100;
    localparam logic [3:0] F_TXE  = 4'b0010;
    localparam logic [3:0] F_RXNE = 4'b0001;

    logic clk;
    logic rst_n;
    bit   steady;
    int   n_sent;
    int   n_offered;
    int   n_directed;
    int   errors;
    int   pending;
    int   checked;

    i2cmts_in_if  in_if ();
    i2cmts_out_if out_if ();

    i2c_master_transfer_sequencer_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    i2cmts_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (in_if),
        .i_cmd     (out_if),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // flags are {start_sent, address_done, tx_empty, rx_full}
    function automatic t_in_item mk(input t_req rq, input logic [6:0] a, input logic [7:0] n,
                                    input logic [3:0] fl, input logic [7:0] txb,
                                    input logic [7:0] rxb);
        t_in_item it;
        it.req_type          = rq;
        it.target_address    = a;
        it.transfer_length   = n;
        it.start_sent_flag   = fl[3];
        it.address_done_flag = fl[2];
        it.tx_empty_flag     = fl[1];
        it.rx_full_flag      = fl[0];
        it.tx_byte           = txb;
        it.rx_byte           = rxb;
        return it;
    endfunction

    function automatic t_in_item status_with(input logic [3:0] fl);
        return mk(REQ_STATUS, 7'($urandom), 8'($urandom), fl, 8'($urandom), 8'($urandom));
    endfunction

    function automatic t_in_item any_req();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    task automatic send(input t_in_item it, input bit counts);
        int gap;
        steady = ((n_sent / 150) % 4 == 3);
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge clk); while (!in_if.ready);
        n_offered++;
        if (counts)
            n_sent++;
    endtask

    // status with the awaited flag clear, sometimes
    task automatic maybe_idle_status(input logic [3:0] fl);
        if ($urandom_range(0, 9) == 0)
            send(status_with(4'($urandom) & ~fl), 1'b0);
    endtask

    // occasional break-off: error plus recovery, or just leave it for a restart
    task automatic maybe_break(output bit quit);
        quit = ($urandom_range(0, 49) == 0);
        if (quit && $urandom_range(0, 1) == 1) begin
            send(mk(REQ_ERROR, 7'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                    8'($urandom)), 1'b1);
            if ($urandom_range(0, 3) == 0)
                send(mk(REQ_ERROR, 7'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                        8'($urandom)), 1'b1);
            send(status_with(4'($urandom)), 1'b1);
        end
    endtask

    task automatic run_transfer(input bit zero_read);
        int       len;
        int       pick;
        int       nev;
        bit       rd;
        bit       quit;
        logic [3:0] fl;
        rd   = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        if (pick < 75)      len = $urandom_range(1, 6);
        else if (pick < 88) len = 0;
        else if (pick < 99) len = $urandom_range(7, 40);
        else                len = $urandom_range(200, 255);
        if (len == 0 && rd && $urandom_range(0, 7) != 0)
            rd = 1'b0;
        if (zero_read) begin
            len = 0;
            rd  = 1'b1;
        end
        send(mk(rd ? REQ_START_RD : REQ_START_WR, 7'($urandom), 8'(len), 4'($urandom),
                8'($urandom), 8'($urandom)), 1'b1);
        maybe_break(quit);
        if (quit) return;
        maybe_idle_status(F_SB);
        send(status_with(F_SB | 4'($urandom)), 1'b1);
        maybe_break(quit);
        if (quit) return;
        maybe_idle_status(F_ADF);
        send(status_with(F_ADF | 4'($urandom)), 1'b1);
        fl  = rd ? F_RXNE : F_TXE;
        // a zero-length read only stops once the index wraps
        nev = rd ? ((len == 0) ? 256 : len) : len + 1;
        for (int i = 0; i < nev; i++) begin
            if (!zero_read) begin
                maybe_break(quit);
                if (quit) return;
            end
            maybe_idle_status(fl);
            send(status_with(fl | 4'($urandom)), 1'b1);
        end
    endtask

    // stimulus
    initial begin
        rst_n       <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        n_sent    = 0;
        n_offered = 0;
        steady    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle, error recovery, extremes, restart while busy
        send(mk(REQ_STATUS,   7'h00, 8'h00, 4'hF, 8'hFF, 8'hFF), 1'b1);
        send(mk(REQ_ERROR,    7'h00, 8'h00, 4'h0, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, 4'h0, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_START_WR, 7'h7F, 8'h00, 4'h0, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, 4'h7, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_SB, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_ADF, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_TXE, 8'hFF, 8'h00), 1'b1);
        send(mk(REQ_START_RD, 7'h00, 8'h01, 4'h0, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_SB, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_ADF, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_RXNE, 8'h00, 8'hFF), 1'b1);
        send(mk(REQ_START_WR, 7'h55, 8'hFF, 4'h0, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_SB, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_ADF, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_TXE, 8'hA5, 8'h00), 1'b1);
        send(mk(REQ_START_RD, 7'h2A, 8'h03, 4'h0, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_SB, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_ADF, 8'h00, 8'h00), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_RXNE, 8'h00, 8'h5A), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, F_RXNE, 8'h00, 8'hC3), 1'b1);
        send(mk(REQ_ERROR,    7'h7F, 8'hFF, 4'hF, 8'hFF, 8'hFF), 1'b1);
        send(mk(REQ_STATUS,   7'h00, 8'h00, 4'h0, 8'h00, 8'h00), 1'b1);
        n_directed = n_sent;

        run_transfer(1'b1);
        while (n_sent < 1500) begin
            if ($urandom_range(0, 19) == 0)
                send(any_req(), 1'b1);
            else
                run_transfer(1'b0);
        end
        in_if.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        $display("covered %0d requests (%0d directed, %0d offered in all), %0d commands compared",
                 n_sent, n_directed, n_offered, checked);
        $display("including zero-length read with index wrap and a long output hold-off");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // command side: random stalls plus one long hold-off to back up the pipeline
    initial begin : cmd_side
        int stall;
        int taken;
        bit held;
        out_if.ready <= 1'b0;
        taken = 0;
        held  = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (!held && taken == 300) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (200) @(posedge clk);
            end else begin
                stall = steady ? 0 : $urandom_range(0, 3);
                if (stall != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!out_if.valid);
            taken++;
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: i2c_master_transfer_sequencer_top.f
design/i2cmts_pkg.sv
design/i2cmts_in_if.sv
design/i2cmts_out_if.sv
design/i2cmts_step.sv
design/i2c_master_transfer_sequencer_top.sv
tb/i2cmts_checker.sv
tb/tb_top.sv
